[rtl/core/morse_led_segment_encoder_defines.svh]
// Assertion macros shared by the Morse LED segment encoder RTL.
`ifndef MORSE_LED_SEGMENT_ENCODER_DEFINES_SVH
`define MORSE_LED_SEGMENT_ENCODER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MLSE_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mlse assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MLSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mlse assertion failed");

`endif

[rtl/core/mlse_pkg.sv]
// Package with types, constants and the character code table of the Morse encoder.
package mlse_pkg;

    localparam int unsigned CFG_WIDTH = 16;
    localparam int unsigned CFG_ADDR_WIDTH = 2;
    localparam int unsigned CHAR_WIDTH = 8;
    localparam int unsigned MAX_SYMBOLS = 5;
    localparam int unsigned SYM_CNT_WIDTH = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DOT_ON = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DASH_ON = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SYMBOL_OFF = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LETTER_GAP = 2'd3;

    // Reset values of the timing registers, in milliseconds.
    localparam logic [CFG_WIDTH-1:0] DOT_ON_RESET = 16'd500;
    localparam logic [CFG_WIDTH-1:0] DASH_ON_RESET = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] SYMBOL_OFF_RESET = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] LETTER_GAP_RESET = 16'd2500;

    // Character codes that bound the encoded ranges.
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DIGIT_FIRST = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DIGIT_LAST = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_FIRST = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_LAST = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_FIRST = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_LAST = 8'h7A;

    // Timing register set.
    typedef struct packed {
        logic [CFG_WIDTH-1:0] dot_on_ms;
        logic [CFG_WIDTH-1:0] dash_on_ms;
        logic [CFG_WIDTH-1:0] symbol_off_ms;
        logic [CFG_WIDTH-1:0] letter_gap_ms;
    } cfg_t;

    // One LED segment as it leaves the sequencer.
    typedef struct packed {
        logic                 led_on;
        logic [CFG_WIDTH-1:0] duration_ms;
        logic                 last_segment;
    } seg_t;

    // Table entry: symbol count, then one bit per symbol (bit 0 first, 1 = dash).
    typedef struct packed {
        logic [SYM_CNT_WIDTH-1:0] len;
        logic [MAX_SYMBOLS-1:0]   pat;
    } code_entry_t;

    // Decoded character.
    typedef struct packed {
        logic        valid;
        logic        space;
        code_entry_t code;
    } char_info_t;

    localparam code_entry_t LETTER_TABLE [26] = '{
        '{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
        '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
        '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
        '{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
        '{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
        '{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
        '{3'd4, 5'b01101}, '{3'd4, 5'b00011}
    };

    localparam code_entry_t DIGIT_TABLE [10] = '{
        '{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
        '{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
        '{3'd5, 5'b00111}, '{3'd5, 5'b01111}
    };

    // Maps a character byte to its Morse symbols; letters fold to one case.
    function automatic char_info_t decode_char(input logic [CHAR_WIDTH-1:0] c);
        char_info_t info;
        logic       is_letter;
        logic       is_digit;
        logic [4:0] letter_idx;
        info = '0;
        is_letter = ((c >= CHAR_UPPER_FIRST) && (c <= CHAR_UPPER_LAST)) ||
                    ((c >= CHAR_LOWER_FIRST) && (c <= CHAR_LOWER_LAST));
        is_digit = (c >= CHAR_DIGIT_FIRST) && (c <= CHAR_DIGIT_LAST);
        letter_idx = c[4:0] - 5'd1;
        if (c == CHAR_SPACE) begin
            info.valid = 1'b1;
            info.space = 1'b1;
        end else if (is_letter) begin
            info.valid = 1'b1;
            info.code = LETTER_TABLE[letter_idx];
        end else if (is_digit) begin
            info.valid = 1'b1;
            info.code = DIGIT_TABLE[c[3:0]];
        end
        return info;
    endfunction

endpackage

[rtl/core/mlse_seq.sv]
// Symbol sequencer that walks one character's Morse code, one segment per step.
module mlse_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [mlse_pkg::CHAR_WIDTH-1:0] char_code,
    input  mlse_pkg::cfg_t                  cfg,
    input  logic                            out_free,
    output logic                            ready,
    output logic                            seg_valid,
    output mlse_pkg::seg_t                  seg
);
    import mlse_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ON   = 4'b0010,
        ST_OFF  = 4'b0100,
        ST_GAP  = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [MAX_SYMBOLS-1:0]   pat_reg, pat_next;
    logic [SYM_CNT_WIDTH-1:0] rem_reg, rem_next;
    char_info_t               info;
    logic                     advance;

    assign info = decode_char(char_code);
    assign ready = (state_reg == ST_IDLE);
    assign seg_valid = (state_reg != ST_IDLE);
    assign advance = seg_valid && out_free;

    // Segment shown for the current step; bit 0 of the pattern is the current symbol.
    always_comb begin
        seg = '0;
        case (state_reg)
            ST_ON: begin
                seg.led_on = 1'b1;
                seg.duration_ms = pat_reg[0] ? cfg.dash_on_ms : cfg.dot_on_ms;
            end
            ST_OFF: begin
                seg.duration_ms = cfg.symbol_off_ms;
            end
            ST_GAP: begin
                seg.duration_ms = cfg.letter_gap_ms;
                seg.last_segment = 1'b1;
            end
            default: begin
                seg = '0;
            end
        endcase
    end

    // Next-state logic: load on a new transaction, step while the output takes segments.
    always_comb begin
        state_next = state_reg;
        pat_next = pat_reg;
        rem_next = rem_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start && info.valid) begin
                    pat_next = info.code.pat;
                    rem_next = info.code.len;
                    state_next = info.space ? ST_GAP : ST_ON;
                end
            end
            ST_ON: begin
                if (advance) begin
                    state_next = ST_OFF;
                end
            end
            ST_OFF: begin
                if (advance) begin
                    pat_next = pat_reg >> 1;
                    rem_next = rem_reg - 3'd1;
                    state_next = (rem_reg == 3'd1) ? ST_GAP : ST_ON;
                end
            end
            ST_GAP: begin
                if (advance) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register with synchronous reset; the symbol shifter needs none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pat_reg <= pat_next;
        rem_reg <= rem_next;
    end

endmodule

[rtl/core/morse_led_segment_encoder.sv]
// Top level of the Morse LED segment encoder: timing registers, sequencer and output stage.
//
//  Channel   Ports                                          Direction
//  input     s_valid s_ready s_char_code                    in
//  result    m_valid m_ready m_led_on m_duration_ms m_last_segment  out
//  config    cfg_wr_en cfg_addr cfg_wdata                   in
//
// After its transaction a letter or digit keeps s_ready low while it issues 2 * symbols + 1
// segments (3 to 11), closing with the gap; a space keeps s_ready low for its single gap
// segment, and any other byte is accepted with no output.
// Synchronous active-low reset returns the timing registers to 500/1000/1000/2500 ms.
// A stalled result holds in the output register and freezes the sequencer; a new
// transaction is taken again once the closing gap segment has moved to the output register.
`include "morse_led_segment_encoder_defines.svh"

module morse_led_segment_encoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mlse_pkg::CHAR_WIDTH-1:0]     s_char_code,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_led_on,
    output logic [mlse_pkg::CFG_WIDTH-1:0]      m_duration_ms,
    output logic                                m_last_segment,
    input  logic                                cfg_wr_en,
    input  logic [mlse_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [mlse_pkg::CFG_WIDTH-1:0]      cfg_wdata
);
    import mlse_pkg::*;

    cfg_t  cfg_reg;
    seg_t  seg;
    seg_t  out_reg;
    logic  m_valid_reg;
    logic  seg_valid;
    logic  out_free;
    logic  seq_ready;
    logic  load_out;

    // Timing registers, written through the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dot_on_ms <= DOT_ON_RESET;
            cfg_reg.dash_on_ms <= DASH_ON_RESET;
            cfg_reg.symbol_off_ms <= SYMBOL_OFF_RESET;
            cfg_reg.letter_gap_ms <= LETTER_GAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DOT_ON:     cfg_reg.dot_on_ms <= cfg_wdata;
                REG_DASH_ON:    cfg_reg.dash_on_ms <= cfg_wdata;
                REG_SYMBOL_OFF: cfg_reg.symbol_off_ms <= cfg_wdata;
                REG_LETTER_GAP: cfg_reg.letter_gap_ms <= cfg_wdata;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The sequencer walks the symbols of one character.
    mlse_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && s_ready),
        .char_code (s_char_code),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .ready     (seq_ready),
        .seg_valid (seg_valid),
        .seg       (seg)
    );

    assign s_ready = seq_ready;

    // Output register: takes a new segment whenever it is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = seg_valid && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= seg_valid;
        end
        if (load_out) begin
            out_reg <= seg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_led_on = out_reg.led_on;
    assign m_duration_ms = out_reg.duration_ms;
    assign m_last_segment = out_reg.last_segment;

    // Once the closing gap leaves the sequencer, the block takes a new transaction.
    `MLSE_ASSERT_NEXT(a_ready_after_gap, aclk, aresetn,
        load_out && seg.last_segment, s_ready)
    // A lit segment never closes a character.
    `MLSE_ASSERT_SAME(a_lit_not_last, aclk, aresetn,
        m_valid && m_led_on, !m_last_segment)
    // A space keeps the block busy for its gap segment.
    `MLSE_ASSERT_NEXT(a_space_busy, aclk, aresetn,
        s_valid && s_ready && (s_char_code == CHAR_SPACE), !s_ready && seg_valid)

endmodule
